>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property that must never hold at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("forbidden condition seen");

`endif

>>> hw/rtl/ppmfm_pkg.sv
// Types, constants and codes of the pulse period median flow meter.
// Used by every module of the block; depends on nothing.
package ppmfm_pkg;

   localparam int WINDOW_MAX_DEF = 5;
   localparam int TIME_BITS_DEF  = 40;

   localparam int PERIOD_W = 30;
   localparam int PPL_W    = 16;
   localparam int FLOW_W   = 31;
   localparam int DEN_W    = PERIOD_W + PPL_W;
   localparam int NUM_W    = DEN_W + 1;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam logic [NUM_W-1:0]  FLOW_NUM2 = 47'd7864320000000;
   localparam logic [FLOW_W-1:0] FLOW_MAX  = 31'h7FFF_FFFF;

   localparam logic [2:0] REG_PPL       = 3'd0;
   localparam logic [2:0] REG_MIN_PER   = 3'd1;
   localparam logic [2:0] REG_WIN_SIZE  = 3'd2;
   localparam logic [2:0] REG_STALE     = 3'd3;
   localparam logic [2:0] REG_INV_LIMIT = 3'd4;
   localparam logic [2:0] REG_MAX_GAP   = 3'd5;

   localparam logic [1:0] FUNC_EDGE  = 2'd0;
   localparam logic [1:0] FUNC_POLL  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   localparam logic [1:0] MODE_READY   = 2'd0;
   localparam logic [1:0] MODE_RUNNING = 2'd1;
   localparam logic [1:0] MODE_ERROR   = 2'd2;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_ACCEPTED  = 3'd1;
   localparam logic [2:0] EV_OUTLIER   = 3'd2;
   localparam logic [2:0] EV_INVALID   = 3'd3;
   localparam logic [2:0] EV_INV_RESET = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MEDIAN,
      ST_APPLY,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [39:0] time_us;
   } req_type;

   typedef struct packed {
      logic [FLOW_W-1:0]   flow_rate_q16;
      logic [PERIOD_W-1:0] smooth_period;
      logic                data_valid;
      logic [1:0]          mode;
      logic [2:0]          edge_event;
   } rsp_type;

   typedef struct packed {
      logic clr;
      logic wr;
      logic active;
   } cell_ctl_type;

endpackage

>>> hw/rtl/pulse_period_median_flow_meter.sv
// Top level of the pulse period median flow meter: control, window cells, divider.
// Depends on ppmfm_pkg, ppmfm_cell and ppmfm_div.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (func, time_us)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (flow, period, valid, mode, event)
//   csr      in         csr_we               csr_addr, csr_wdata
//
// An accepted item passes through the decide state, then median search and apply
// when a full window needs its median, then multiply, start, divide and done.
// The flow division is bit-serial with 47 steps.
// Synchronous reset clears control state and window cells; registers get defaults.
// A result waits in the output register while the next item is accepted.
module pulse_period_median_flow_meter #(
   parameter int WINDOW_MAX = ppmfm_pkg::WINDOW_MAX_DEF,
   parameter int TIME_BITS  = ppmfm_pkg::TIME_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppmfm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppmfm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [31:0]       csr_wdata
);

   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int PW = ppmfm_pkg::PERIOD_W;

   ppmfm_pkg::state_type state_ff, state_in;

   logic [15:0] ppl_ff;
   logic [PW-1:0] min_per_ff;
   logic [2:0]  win_size_ff;
   logic [31:0] stale_ff;
   logic [7:0]  inv_limit_ff;
   logic [PW-1:0] max_gap_ff;

   logic [1:0]           func_ff, func_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] last_edge_ff, last_edge_in;
   logic                 have_edge_ff, have_edge_in;
   logic [CW-1:0]        wslot_ff, wslot_in;
   logic [CW-1:0]        filled_ff, filled_in;
   logic [PW-1:0]        smooth_ff, smooth_in;
   logic [7:0]           inv_run_ff, inv_run_in;
   logic [TIME_BITS-1:0] last_valid_ff, last_valid_in;
   logic [1:0]           mode_ff, mode_in;
   logic [2:0]           event_ff, event_in;
   logic [PW-1:0]        per_ff, per_in;
   logic [CW-1:0]        cand_ff, cand_in;
   logic [PW-1:0]        median_ff, median_in;
   logic [ppmfm_pkg::DEN_W-1:0] den_ff, den_in;
   logic                 dvalid_ff, dvalid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ppmfm_pkg::rsp_type   rsp_ff, rsp_in;

   logic [CW-1:0]        n_eff;
   logic [TIME_BITS-1:0] gap;
   logic [TIME_BITS-1:0] age;
   logic [CW-1:0]        slot_fix;
   logic [7:0]           run_inc;
   logic                 clr_cells;
   logic                 wr_en;
   logic [CW-1:0]        wr_slot;
   logic [PW-1:0]        cand_val;
   logic [PW+1:0]        p3, p2, m3, m2;
   logic                 outlier;
   logic                 div_start, div_done, div_sat;
   logic [ppmfm_pkg::FLOW_W-1:0] div_quot;
   logic [CW-1:0]        lt_chain [WINDOW_MAX+1];
   logic [CW-1:0]        le_chain [WINDOW_MAX+1];
   logic [PW-1:0]        cell_val [WINDOW_MAX];

   always_ff @(posedge clock) begin
      if (reset) begin
         ppl_ff       <= 16'd450;
         min_per_ff   <= 30'd1000;
         win_size_ff  <= 3'd5;
         stale_ff     <= 32'd2000000;
         inv_limit_ff <= 8'd5;
         max_gap_ff   <= 30'd1000000000;
      end else if (csr_we) begin
         unique case (csr_addr)
            ppmfm_pkg::REG_PPL:       ppl_ff       <= csr_wdata[15:0];
            ppmfm_pkg::REG_MIN_PER:   min_per_ff   <= csr_wdata[PW-1:0];
            ppmfm_pkg::REG_WIN_SIZE:  win_size_ff  <= csr_wdata[2:0];
            ppmfm_pkg::REG_STALE:     stale_ff     <= csr_wdata;
            ppmfm_pkg::REG_INV_LIMIT: inv_limit_ff <= csr_wdata[7:0];
            ppmfm_pkg::REG_MAX_GAP:   max_gap_ff   <= csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (win_size_ff == 3'd0) begin
         n_eff = CW'(1);
      end else if (32'(win_size_ff) > WINDOW_MAX) begin
         n_eff = CW'(WINDOW_MAX);
      end else begin
         n_eff = CW'(win_size_ff);
      end
   end

   assign lt_chain[0] = '0;
   assign le_chain[0] = '0;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      ppmfm_pkg::cell_ctl_type ctl;
      assign ctl.clr    = clr_cells;
      assign ctl.wr     = wr_en && (wr_slot == CW'(i));
      assign ctl.active = CW'(i) < n_eff;
      ppmfm_cell #(.CNT_W(CW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .wr_data (per_in),
         .cand    (cand_val),
         .lt_in   (lt_chain[i]),
         .le_in   (le_chain[i]),
         .lt_out  (lt_chain[i+1]),
         .le_out  (le_chain[i+1]),
         .value   (cell_val[i])
      );
   end

   always_comb begin
      cand_val = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (cand_ff == CW'(i)) begin
            cand_val = cell_val[i];
         end
      end
   end

   ppmfm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (ppmfm_pkg::FLOW_NUM2 + ppmfm_pkg::NUM_W'(den_ff)),
      .divis ({den_ff, 1'b0}),
      .done  (div_done),
      .quot  (div_quot),
      .sat   (div_sat)
   );

   always_comb begin
      gap      = now_ff - last_edge_ff;
      age      = now_ff - last_valid_ff;
      slot_fix = (wslot_ff >= n_eff) ? '0 : wslot_ff;
      run_inc  = (inv_run_ff == 8'd255) ? inv_run_ff : inv_run_ff + 8'd1;
      p3       = {2'b00, per_ff} + {1'b0, per_ff, 1'b0};
      p2       = {1'b0, per_ff, 1'b0};
      m3       = {2'b00, median_ff} + {1'b0, median_ff, 1'b0};
      m2       = {1'b0, median_ff, 1'b0};
      outlier  = (p3 < m2) || (p2 > m3);

      state_in      = state_ff;
      func_in       = func_ff;
      now_in        = now_ff;
      last_edge_in  = last_edge_ff;
      have_edge_in  = have_edge_ff;
      wslot_in      = wslot_ff;
      filled_in     = filled_ff;
      smooth_in     = smooth_ff;
      inv_run_in    = inv_run_ff;
      last_valid_in = last_valid_ff;
      mode_in       = mode_ff;
      event_in      = event_ff;
      per_in        = per_ff;
      cand_in       = cand_ff;
      median_in     = median_ff;
      den_in        = den_ff;
      dvalid_in     = dvalid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      clr_cells     = 1'b0;
      wr_en         = 1'b0;
      wr_slot       = slot_fix;
      div_start     = 1'b0;
      req_stall     = 1'b1;

      unique case (state_ff)
         ppmfm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in  = req_data.func;
               now_in   = TIME_BITS'({24'd0, req_data.time_us});
               event_in = ppmfm_pkg::EV_NONE;
               state_in = ppmfm_pkg::ST_DECIDE;
            end
         end
         ppmfm_pkg::ST_DECIDE: begin
            state_in = ppmfm_pkg::ST_MUL;
            if (func_ff == ppmfm_pkg::FUNC_CLEAR) begin
               last_edge_in  = '0;
               have_edge_in  = 1'b0;
               clr_cells     = 1'b1;
               wslot_in      = '0;
               filled_in     = '0;
               smooth_in     = '0;
               inv_run_in    = '0;
               last_valid_in = '0;
               mode_in       = ppmfm_pkg::MODE_READY;
            end else if (func_ff == ppmfm_pkg::FUNC_EDGE) begin
               if (!have_edge_ff) begin
                  have_edge_in = 1'b1;
                  last_edge_in = now_ff;
               end else if (gap != '0 && gap <= TIME_BITS'(max_gap_ff)) begin
                  last_edge_in = now_ff;
                  per_in       = gap[PW-1:0];
                  if (gap[PW-1:0] > min_per_ff) begin
                     inv_run_in = '0;
                     wslot_in   = slot_fix;
                     if (filled_ff >= n_eff) begin
                        cand_in  = '0;
                        state_in = ppmfm_pkg::ST_MEDIAN;
                     end else begin
                        smooth_in     = gap[PW-1:0];
                        filled_in     = filled_ff + 1'b1;
                        wr_en         = 1'b1;
                        wr_slot       = slot_fix;
                        wslot_in      = (slot_fix + 1'b1 == n_eff) ? '0 : slot_fix + 1'b1;
                        last_valid_in = now_ff;
                        mode_in       = ppmfm_pkg::MODE_RUNNING;
                        event_in      = ppmfm_pkg::EV_ACCEPTED;
                     end
                  end else begin
                     inv_run_in = run_inc;
                     if (run_inc >= inv_limit_ff) begin
                        filled_in = '0;
                        clr_cells = 1'b1;
                        mode_in   = ppmfm_pkg::MODE_ERROR;
                        event_in  = ppmfm_pkg::EV_INV_RESET;
                     end else begin
                        event_in = ppmfm_pkg::EV_INVALID;
                     end
                  end
               end
            end
         end
         ppmfm_pkg::ST_MEDIAN: begin
            if (lt_chain[WINDOW_MAX] <= (n_eff >> 1) && (n_eff >> 1) < le_chain[WINDOW_MAX]) begin
               median_in = cand_val;
               state_in  = ppmfm_pkg::ST_APPLY;
            end else begin
               cand_in = cand_ff + 1'b1;
            end
         end
         ppmfm_pkg::ST_APPLY: begin
            smooth_in     = outlier ? median_ff : per_ff;
            event_in      = outlier ? ppmfm_pkg::EV_OUTLIER : ppmfm_pkg::EV_ACCEPTED;
            wr_en         = 1'b1;
            wr_slot       = wslot_ff;
            wslot_in      = (wslot_ff + 1'b1 == n_eff) ? '0 : wslot_ff + 1'b1;
            last_valid_in = now_ff;
            mode_in       = ppmfm_pkg::MODE_RUNNING;
            state_in      = ppmfm_pkg::ST_MUL;
         end
         ppmfm_pkg::ST_MUL: begin
            den_in    = smooth_ff * ppl_ff;
            dvalid_in = (mode_ff != ppmfm_pkg::MODE_ERROR) && (age <= TIME_BITS'(stale_ff))
                        && (inv_run_ff < inv_limit_ff) && (filled_ff != '0)
                        && (smooth_ff != '0);
            state_in  = ppmfm_pkg::ST_START;
         end
         ppmfm_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = ppmfm_pkg::ST_DIV;
         end
         ppmfm_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = ppmfm_pkg::ST_DONE;
            end
         end
         ppmfm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (smooth_ff == '0) begin
                  rsp_in.flow_rate_q16 = '0;
               end else if (ppl_ff == '0 || div_sat) begin
                  rsp_in.flow_rate_q16 = ppmfm_pkg::FLOW_MAX;
               end else begin
                  rsp_in.flow_rate_q16 = div_quot;
               end
               rsp_in.smooth_period = smooth_ff;
               rsp_in.data_valid    = dvalid_ff;
               rsp_in.mode          = mode_ff;
               rsp_in.edge_event    = event_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ppmfm_pkg::ST_IDLE;
            end
         end
         default: state_in = ppmfm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ppmfm_pkg::ST_IDLE;
         last_edge_ff  <= '0;
         have_edge_ff  <= 1'b0;
         wslot_ff      <= '0;
         filled_ff     <= '0;
         smooth_ff     <= '0;
         inv_run_ff    <= '0;
         last_valid_ff <= '0;
         mode_ff       <= ppmfm_pkg::MODE_READY;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_edge_ff  <= last_edge_in;
         have_edge_ff  <= have_edge_in;
         wslot_ff      <= wslot_in;
         filled_ff     <= filled_in;
         smooth_ff     <= smooth_in;
         inv_run_ff    <= inv_run_in;
         last_valid_ff <= last_valid_in;
         mode_ff       <= mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff   <= func_in;
      now_ff    <= now_in;
      event_ff  <= event_in;
      per_ff    <= per_in;
      cand_ff   <= cand_in;
      median_ff <= median_in;
      den_ff    <= den_in;
      dvalid_ff <= dvalid_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/ppmfm_cell.sv
// One window cell: holds a stored period and adds its rank votes to the chain.
// Depends on ppmfm_pkg.
module ppmfm_cell #(
   parameter int CNT_W = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ppmfm_pkg::cell_ctl_type       ctl,
   input  logic [ppmfm_pkg::PERIOD_W-1:0] wr_data,
   input  logic [ppmfm_pkg::PERIOD_W-1:0] cand,
   input  logic [CNT_W-1:0]              lt_in,
   input  logic [CNT_W-1:0]              le_in,
   output logic [CNT_W-1:0]              lt_out,
   output logic [CNT_W-1:0]              le_out,
   output logic [ppmfm_pkg::PERIOD_W-1:0] value
);

   logic [ppmfm_pkg::PERIOD_W-1:0] value_ff;
   logic [ppmfm_pkg::PERIOD_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.clr) begin
         value_in = '0;
      end else if (ctl.wr) begin
         value_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign lt_out = lt_in + CNT_W'(ctl.active && (value_ff < cand));
   assign le_out = le_in + CNT_W'(ctl.active && (value_ff <= cand));
   assign value  = value_ff;

endmodule

>>> hw/rtl/ppmfm_div.sv
// Restoring divider, one quotient bit per cycle, with a flag for quotients that overflow.
// Depends on ppmfm_pkg.
module ppmfm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ppmfm_pkg::NUM_W-1:0]   numer,
   input  logic [ppmfm_pkg::NUM_W-1:0]   divis,
   output logic                          done,
   output logic [ppmfm_pkg::FLOW_W-1:0]  quot,
   output logic                          sat
);

   localparam int NW = ppmfm_pkg::NUM_W;
   localparam int FW = ppmfm_pkg::FLOW_W;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ppmfm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]                 rem_ff, rem_in;
   logic [NW-1:0]                 num_ff, num_in;
   logic [NW-1:0]                 div_ff, div_in;
   logic [FW-1:0]                 q_ff, q_in;
   logic                          sat_ff, sat_in;
   logic [NW:0]                   shifted;
   logic                          ge;

   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      ge      = shifted >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = numer;
         div_in  = divis;
         q_in    = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? NW'(shifted - {1'b0, div_ff}) : shifted[NW-1:0];
         num_in = {num_ff[NW-2:0], 1'b0};
         q_in   = {q_ff[FW-2:0], ge};
         sat_in = sat_ff | q_ff[FW-1];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ppmfm_pkg::DIV_CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign sat  = sat_ff;

endmodule

>>> hw/rtl/ppmfm_checker.sv
// Port-level checks of the pulse period median flow meter, bound to its top level.
// Depends on ppmfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ppmfm_assertions (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ppmfm_pkg::rsp_type rsp_data
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `ASSERT_CLK(a_req_one_item, clock, reset, req_valid && !req_stall |=> req_stall)
   `ASSERT_CLK(a_valid_running, clock, reset, rsp_valid && rsp_data.data_valid |-> rsp_data.mode == ppmfm_pkg::MODE_RUNNING)
   `ASSERT_CLK(a_zero_period, clock, reset, rsp_valid && rsp_data.smooth_period == '0 |-> rsp_data.flow_rate_q16 == '0 && !rsp_data.data_valid)
   `ASSERT_NEVER(a_accept_state, clock, reset, rsp_valid && (rsp_data.edge_event == ppmfm_pkg::EV_ACCEPTED || rsp_data.edge_event == ppmfm_pkg::EV_OUTLIER) && rsp_data.mode != ppmfm_pkg::MODE_RUNNING)

endmodule

bind pulse_period_median_flow_meter ppmfm_assertions u_ppmfm_assertions (.*);
